>>> hw/rtl/adcss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adcss_pkg
// Types, codes and slot tables for the ADC scan sequencer with smoothing.
// ----------------------------------------------------------------------------
package adcss_pkg;

    localparam int CFG_W   = 8;
    localparam int MODE_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int CHAN_W  = 3;
    localparam int PINS_W  = 6;
    localparam int STEP_W  = 4;
    localparam int PHASE_W = 2;
    localparam int KIND_W  = 2;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CONV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd1;
    localparam logic [STEP_W-1:0] STEP_THUMB = 4'd8;

    localparam logic [PINS_W-1:0] IDLE_PATTERN  = 6'h20;
    localparam logic [CFG_W-1:0]  WEIGHT_RESET  = 8'd192;

    typedef struct packed {
        logic [CHAN_W-1:0] next_channel;
        logic              start_conversion;
        logic [PINS_W-1:0] thumb_pins;
        logic              scan_busy;
    } stat_t;

    // Slot updated by scan steps one to seven.
    function automatic logic [SLOT_W-1:0] step_slot(input logic [STEP_W-1:0] step);
        logic [SLOT_W-1:0] slot;
        case (step)
            4'd1:    slot = 4'd3;
            4'd2:    slot = 4'd4;
            4'd3:    slot = 4'd6;
            4'd4:    slot = 4'd7;
            4'd5:    slot = 4'd8;
            4'd6:    slot = 4'd1;
            default: slot = 4'd0;
        endcase
        return slot;
    endfunction

    function automatic logic [SLOT_W-1:0] thumb_slot(input logic [PHASE_W-1:0] phase);
        logic [SLOT_W-1:0] slot;
        case (phase)
            2'd0:    slot = 4'd15;
            2'd1:    slot = 4'd14;
            2'd2:    slot = 4'd12;
            default: slot = 4'd13;
        endcase
        return slot;
    endfunction

    function automatic logic [PINS_W-1:0] thumb_next(input logic [PHASE_W-1:0] phase);
        logic [PINS_W-1:0] pins;
        case (phase)
            2'd0:    pins = 6'h01;
            2'd1:    pins = 6'h22;
            2'd2:    pins = 6'h23;
            default: pins = 6'h00;
        endcase
        return pins;
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/adc_scan_sequencer_with_smoothing_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adc_scan_sequencer_with_smoothing_core
// Sequences an ADC channel scan and keeps an exponentially smoothed value
// per slot in a small synchronous memory.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one command per transfer: a scan start, a
// finished conversion with its sample, or a slot read. Every input transfer
// produces exactly one output transfer with the filtered value, the slot
// written, and the sequencer status (next channel, conversion request,
// thumb multiplexer pins, busy flag).
// The smoothing weight is written through the cfg channel, which is always
// ready; it should only be changed while no command is in flight.
// A command is accepted every cycle while the output is free or taken. The
// slot memory is read on the accepting edge, stage one forms the weight
// multiply, stage two the add and the write back. Reads and updates of
// the same slot in consecutive commands are forwarded around the memory.
// When the receiver stalls, the whole pipeline holds and in_ready drops
// until the output register is taken.
// Reset clears the sequencer, sets the weight to 192, the thumb pins to
// their idle pattern, and marks every slot as zero through per-slot valid
// bits, so the block is usable as soon as reset is released.
// ----------------------------------------------------------------------------
module adc_scan_sequencer_with_smoothing_core #(
    parameter int NUM_SLOTS   = 16,
    parameter int SAMPLE_BITS = 10,
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [adcss_pkg::CFG_W-1:0]   cfg_data,

    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [adcss_pkg::MODE_W-1:0]  mode,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    input  wire logic [adcss_pkg::SLOT_W-1:0]  read_slot,

    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [SAMPLE_BITS-1:0]             filtered_value,
    output logic [adcss_pkg::SLOT_W-1:0]       written_slot,
    output logic                               write_valid,
    output logic [adcss_pkg::CHAN_W-1:0]       next_channel,
    output logic                               start_conversion,
    output logic [adcss_pkg::PINS_W-1:0]       thumb_pins,
    output logic                               scan_busy
);
    import adcss_pkg::*;

    localparam int ADDR_W = $clog2(NUM_SLOTS);
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS + 2;

    logic [WEIGHT_BITS-1:0]   weight_reg;
    logic [STEP_W-1:0]        scan_step_reg, scan_step_next;
    logic [PHASE_W-1:0]       thumb_phase_reg, thumb_phase_next;
    logic [PINS_W-1:0]        thumb_pattern_reg, thumb_pattern_next;

    logic [SAMPLE_BITS-1:0]   mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]     vld_reg;
    logic [SAMPLE_BITS-1:0]   rd_data_reg;
    logic                     rd_vld_reg;

    logic                     advance;
    logic                     accept;
    logic [KIND_W-1:0]        s0_kind;
    logic [SLOT_W-1:0]        s0_slot;
    stat_t                    s0_stat;

    logic                     s1_valid_reg;
    logic [KIND_W-1:0]        s1_kind_reg;
    logic [SLOT_W-1:0]        s1_slot_reg;
    logic [SAMPLE_BITS-1:0]   s1_sample_reg;
    stat_t                    s1_stat_reg;
    logic [SAMPLE_BITS-1:0]   s1_old;
    logic signed [DIFF_W-1:0] s1_diff;
    logic signed [PROD_W-1:0] s1_prod;

    logic                     s2_valid_reg;
    logic [KIND_W-1:0]        s2_kind_reg;
    logic [SLOT_W-1:0]        s2_slot_reg;
    logic [SAMPLE_BITS-1:0]   s2_sample_reg;
    logic [SAMPLE_BITS-1:0]   s2_old_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    stat_t                    s2_stat_reg;
    logic signed [PROD_W-1:0] s2_sum;
    logic [SAMPLE_BITS-1:0]   s2_new;
    logic                     s2_write;

    logic                     lw_valid_reg;
    logic [SLOT_W-1:0]        lw_slot_reg;
    logic [SAMPLE_BITS-1:0]   lw_data_reg;

    logic                     out_valid_reg;
    logic [SAMPLE_BITS-1:0]   out_value_reg;
    logic [SLOT_W-1:0]        out_slot_reg;
    logic                     out_wvalid_reg;
    stat_t                    out_stat_reg;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = advance;
    assign accept    = in_valid && advance;
    assign cfg_ready = 1'b1;

    // Command decode and sequencer update.
    always_comb
    begin
        scan_step_next     = scan_step_reg;
        thumb_phase_next   = thumb_phase_reg;
        thumb_pattern_next = thumb_pattern_reg;
        s0_kind            = KIND_NONE;
        s0_slot            = '0;
        s0_stat            = '0;

        unique case (mode)
            MODE_START:
            begin
                if (scan_step_reg == STEP_IDLE)
                begin
                    scan_step_next           = STEP_FIRST;
                    s0_stat.start_conversion = 1'b1;
                end
            end
            MODE_CONV:
            begin
                if (scan_step_reg >= STEP_FIRST && scan_step_reg <= STEP_THUMB)
                begin
                    if (scan_step_reg < STEP_THUMB)
                    begin
                        s0_slot                  = step_slot(scan_step_reg);
                        scan_step_next           = scan_step_reg + STEP_FIRST;
                        s0_stat.start_conversion = 1'b1;
                    end
                    else
                    begin
                        s0_slot            = thumb_slot(thumb_phase_reg);
                        thumb_pattern_next = thumb_next(thumb_phase_reg);
                        thumb_phase_next   = thumb_phase_reg + 2'd1;
                        scan_step_next     = STEP_IDLE;
                    end
                    if (32'(s0_slot) < NUM_SLOTS)
                    begin
                        s0_kind = KIND_WRITE;
                    end
                    else
                    begin
                        s0_slot = '0;
                    end
                end
            end
            MODE_READ:
            begin
                if (32'(read_slot) < NUM_SLOTS)
                begin
                    s0_kind = KIND_READ;
                    s0_slot = read_slot;
                end
            end
            default:
            begin
                s0_kind = KIND_NONE;
            end
        endcase

        s0_stat.next_channel = (scan_step_next != STEP_IDLE) ?
                               CHAN_W'(scan_step_next - STEP_FIRST) : '0;
        s0_stat.thumb_pins   = thumb_pattern_next;
        s0_stat.scan_busy    = (scan_step_next != STEP_IDLE);
    end

    // Slot memory, read at acceptance and written from the last stage.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_data_reg <= mem[s0_slot[ADDR_W-1:0]];
            if (s2_write)
            begin
                mem[s2_slot_reg[ADDR_W-1:0]] <= s2_new;
            end
        end
    end

    // Operand selection with forwarding from the stage ahead and from the
    // write that completed on the acceptance edge.
    always_comb
    begin
        if (s2_write && s2_slot_reg == s1_slot_reg)
        begin
            s1_old = s2_new;
        end
        else if (lw_valid_reg && lw_slot_reg == s1_slot_reg)
        begin
            s1_old = lw_data_reg;
        end
        else if (rd_vld_reg)
        begin
            s1_old = rd_data_reg;
        end
        else
        begin
            s1_old = '0;
        end
    end

    assign s1_diff = $signed({1'b0, s1_old}) - $signed({1'b0, s1_sample_reg});
    assign s1_prod = PROD_W'(s1_diff) * $signed(PROD_W'({1'b0, weight_reg}));

    assign s2_write = s2_valid_reg && (s2_kind_reg == KIND_WRITE);
    assign s2_sum   = $signed(PROD_W'(s2_sample_reg)) + (s2_prod_reg >>> WEIGHT_BITS);
    assign s2_new   = s2_sum[SAMPLE_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg        <= WEIGHT_BITS'(WEIGHT_RESET);
            scan_step_reg     <= STEP_IDLE;
            thumb_phase_reg   <= '0;
            thumb_pattern_reg <= IDLE_PATTERN;
            vld_reg           <= '0;
            rd_vld_reg        <= 1'b0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            lw_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                weight_reg <= WEIGHT_BITS'(cfg_data);
            end
            if (accept)
            begin
                scan_step_reg     <= scan_step_next;
                thumb_phase_reg   <= thumb_phase_next;
                thumb_pattern_reg <= thumb_pattern_next;
            end
            if (advance)
            begin
                rd_vld_reg    <= vld_reg[s0_slot[ADDR_W-1:0]];
                s1_valid_reg  <= accept;
                s2_valid_reg  <= s1_valid_reg;
                lw_valid_reg  <= s2_write;
                out_valid_reg <= s2_valid_reg;
                if (s2_write)
                begin
                    vld_reg[s2_slot_reg[ADDR_W-1:0]] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg   <= s0_kind;
            s1_slot_reg   <= s0_slot;
            s1_sample_reg <= sample;
            s1_stat_reg   <= s0_stat;

            s2_kind_reg   <= s1_kind_reg;
            s2_slot_reg   <= s1_slot_reg;
            s2_sample_reg <= s1_sample_reg;
            s2_old_reg    <= s1_old;
            s2_prod_reg   <= s1_prod;
            s2_stat_reg   <= s1_stat_reg;

            lw_slot_reg   <= s2_slot_reg;
            lw_data_reg   <= s2_new;

            out_slot_reg   <= s2_write ? s2_slot_reg : '0;
            out_wvalid_reg <= s2_write;
            out_stat_reg   <= s2_stat_reg;
            case (s2_kind_reg)
                KIND_WRITE: out_value_reg <= s2_new;
                KIND_READ:  out_value_reg <= s2_old_reg;
                default:    out_value_reg <= '0;
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign filtered_value   = out_value_reg;
    assign written_slot     = out_slot_reg;
    assign write_valid      = out_wvalid_reg;
    assign next_channel     = out_stat_reg.next_channel;
    assign start_conversion = out_stat_reg.start_conversion;
    assign thumb_pins       = out_stat_reg.thumb_pins;
    assign scan_busy        = out_stat_reg.scan_busy;

`ifndef SYNTH
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_step_reg <= STEP_THUMB)
        else $error("scan step out of range");

    a_phase_at_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(thumb_phase_reg) |->
            ($past(scan_step_reg) == STEP_THUMB && scan_step_reg == STEP_IDLE))
        else $error("thumb phase moved outside the end of a scan");

    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_wvalid_reg) |->
            (out_stat_reg.start_conversion == out_stat_reg.scan_busy))
        else $error("conversion request disagrees with busy flag on a write");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stat_reg.start_conversion) |-> out_stat_reg.scan_busy)
        else $error("conversion requested while idle");

    a_write_slot: assert property (@(posedge clk) disable iff (!rst_n)
        s2_write |-> (32'(s2_slot_reg) < NUM_SLOTS))
        else $error("write to a slot beyond the store");
`endif

endmodule
`default_nettype wire
